>>> rtl/core/lpnfc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpnfc_pkg
// Shared types and codes for the length-prefixed NAL frame classifier.
// ----------------------------------------------------------------------------
package lpnfc_pkg;

  typedef enum logic [1:0] {
    KIND_DELTA    = 2'd0,
    KIND_KEYFRAME = 2'd1,
    KIND_PARAMS   = 2'd2
  } kind_e;

  // Configuration register indexes
  localparam logic CFG_CODEC_SELECT   = 1'b0;
  localparam logic CFG_KEY_OUTRANKS   = 1'b1;

  // One byte request, already classified as if it were a unit header
  typedef struct packed {
    logic [7:0] data;
    logic       last;
    kind_e      kind;
  } entry_t;

endpackage
`default_nettype wire

>>> rtl/core/lpnfc_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpnfc_front
// Input side: takes byte requests and tags each with its header kind.
// ----------------------------------------------------------------------------
module lpnfc_front import lpnfc_pkg::*; (
  input  wire logic       in_valid_i,
  input  wire logic [7:0] frame_byte_i,
  input  wire logic       last_byte_i,
  input  wire logic       codec_sel_i,
  input  wire logic       q_ready_i,
  output logic            in_ready_o,
  output logic            push_o,
  output entry_t          entry_o
);

  localparam logic [4:0] AvcTypeIdr    = 5'd5;
  localparam logic [4:0] AvcTypeSps    = 5'd7;
  localparam logic [4:0] AvcTypePps    = 5'd8;
  localparam logic [5:0] HevcKeyLo     = 6'd16;
  localparam logic [5:0] HevcKeyHi     = 6'd23;
  localparam logic [5:0] HevcParamLo   = 6'd32;
  localparam logic [5:0] HevcParamHi   = 6'd34;

  logic [4:0] avc_type;
  logic [5:0] hevc_type;
  kind_e      kind;

  assign avc_type  = frame_byte_i[4:0];
  assign hevc_type = frame_byte_i[6:1];

  always_comb begin
    kind = KIND_DELTA;
    if (codec_sel_i) begin
      if (hevc_type inside {[HevcKeyLo:HevcKeyHi]}) begin
        kind = KIND_KEYFRAME;
      end else if (hevc_type inside {[HevcParamLo:HevcParamHi]}) begin
        kind = KIND_PARAMS;
      end
    end else begin
      if (avc_type == AvcTypeIdr) begin
        kind = KIND_KEYFRAME;
      end else if (avc_type inside {AvcTypeSps, AvcTypePps}) begin
        kind = KIND_PARAMS;
      end
    end
  end

  assign in_ready_o    = q_ready_i;
  assign push_o        = in_valid_i & q_ready_i;
  assign entry_o.data  = frame_byte_i;
  assign entry_o.last  = last_byte_i;
  assign entry_o.kind  = kind;

endmodule
`default_nettype wire

>>> rtl/core/lpnfc_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpnfc_queue
// Two-entry queue between the classifying front and the parsing back.
// ----------------------------------------------------------------------------
module lpnfc_queue import lpnfc_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire logic   push_i,
  input  entry_t      push_entry_i,
  output logic        ready_o,
  input  wire logic   pop_i,
  output logic        valid_o,
  output entry_t      head_o
);

  entry_t     mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       do_push, do_pop;

  assign ready_o = (cnt_q != 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign head_o  = mem_q[rd_ptr_q];
  assign do_push = push_i & ready_o;
  assign do_pop  = pop_i & valid_o;

  always_comb begin
    wr_ptr_d = do_push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = do_pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/lpnfc_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lpnfc_back
// Parser: walks length prefixes and unit bodies, tracks the best unit kind
// and registers the frame result on the last byte.
// ----------------------------------------------------------------------------
module lpnfc_back import lpnfc_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       key_outranks_i,
  input  wire logic       q_valid_i,
  input  entry_t          q_head_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [1:0]      frame_kind_o
);

  typedef enum logic [1:0] {
    PH_PREFIX  = 2'd0,
    PH_BODY    = 2'd1,
    PH_STOPPED = 2'd2
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [1:0]  cnt_q, cnt_d;
  logic [31:0] len_q, len_d;
  logic [31:0] rem_q, rem_d;
  kind_e       pend_q, pend_d;
  kind_e       best_q, best_d;
  logic        out_valid_q, out_valid_d;
  kind_e       out_kind_q, out_kind_d;
  logic [31:0] len_shift;
  logic [31:0] rem_dec;
  kind_e       pend_now;

  function automatic logic [1:0] rank_of(kind_e k, logic key_hi);
    logic [1:0] r;
    case (k)
      KIND_DELTA:    r = 2'd0;
      KIND_KEYFRAME: r = key_hi ? 2'd2 : 2'd1;
      default:       r = key_hi ? 2'd1 : 2'd2;
    endcase
    return r;
  endfunction

  assign pop_o        = q_valid_i & (~out_valid_q | out_ready_i);
  assign out_valid_o  = out_valid_q;
  assign frame_kind_o = out_kind_q;
  assign len_shift    = {len_q[23:0], q_head_i.data};
  assign rem_dec      = rem_q - 32'd1;
  assign pend_now     = (rem_q == len_q) ? q_head_i.kind : pend_q;

  always_comb begin
    phase_d     = phase_q;
    cnt_d       = cnt_q;
    len_d       = len_q;
    rem_d       = rem_q;
    pend_d      = pend_q;
    best_d      = best_q;
    out_kind_d  = out_kind_q;
    out_valid_d = out_ready_i ? 1'b0 : out_valid_q;
    if (pop_o) begin
      case (phase_q)
        PH_PREFIX: begin
          len_d = len_shift;
          cnt_d = cnt_q + 2'd1;
          if (cnt_q == 2'd3) begin
            if (len_shift == 32'd0) begin
              phase_d = PH_STOPPED;
            end else begin
              rem_d   = len_shift;
              phase_d = PH_BODY;
            end
          end
        end
        PH_BODY: begin
          pend_d = pend_now;
          rem_d  = rem_dec;
          if (rem_dec == 32'd0) begin
            if (rank_of(pend_now, key_outranks_i) > rank_of(best_q, key_outranks_i)) begin
              best_d = pend_now;
            end
            len_d   = 32'd0;
            cnt_d   = 2'd0;
            phase_d = PH_PREFIX;
          end
        end
        PH_STOPPED: begin
          phase_d = PH_STOPPED;
        end
        default: begin
          phase_d = PH_PREFIX;
        end
      endcase
      // emit the frame result and clear parse state for the next frame
      if (q_head_i.last) begin
        out_valid_d = 1'b1;
        out_kind_d  = best_d;
        phase_d     = PH_PREFIX;
        cnt_d       = 2'd0;
        len_d       = 32'd0;
        rem_d       = 32'd0;
        pend_d      = KIND_DELTA;
        best_d      = KIND_DELTA;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_PREFIX;
      cnt_q       <= 2'd0;
      len_q       <= 32'd0;
      rem_q       <= 32'd0;
      pend_q      <= KIND_DELTA;
      best_q      <= KIND_DELTA;
      out_valid_q <= 1'b0;
      out_kind_q  <= KIND_DELTA;
    end else begin
      phase_q     <= phase_d;
      cnt_q       <= cnt_d;
      len_q       <= len_d;
      rem_q       <= rem_d;
      pend_q      <= pend_d;
      best_q      <= best_d;
      out_valid_q <= out_valid_d;
      out_kind_q  <= out_kind_d;
    end
  end

endmodule
`default_nettype wire

>>> rtl/core/length_prefixed_nal_frame_classifier_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// length_prefixed_nal_frame_classifier_unit
// Classifies a length-prefixed NAL frame as delta, keyframe or parameter set.
//
// Input channel (in_valid_i / in_ready_o) carries one frame byte per request
// with last_byte_i on the final byte. Output channel (out_valid_o /
// out_ready_i) carries one frame_kind_o per frame, produced by the last byte.
// A front stage tags every byte with its header kind under the selected
// codec; a two-entry queue feeds the parser, which walks 4-byte big-endian
// lengths and unit bodies and keeps the best-ranked complete unit.
// One byte is taken per cycle while the output is not stalled. The last
// byte reaches out_valid_o through the queue and then the output register.
// The result sits in an output register; while it waits on a stalled receiver
// the parser halts, and the queue keeps taking bytes until it holds two.
// Reset clears parse state, the queue and the output; both configuration
// registers reset to 0 (H.264 rules, parameter set above keyframe).
// Configuration is written through cfg_we_i / cfg_idx_i / cfg_wdata_i.
// ----------------------------------------------------------------------------
module length_prefixed_nal_frame_classifier_unit import lpnfc_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       cfg_we_i,
  input  wire logic       cfg_idx_i,
  input  wire logic       cfg_wdata_i,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] frame_byte_i,
  input  wire logic       last_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [1:0]      frame_kind_o
);

  logic   codec_sel_q;
  logic   key_outranks_q;
  logic   q_ready, push, pop, q_valid;
  entry_t push_entry, head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      codec_sel_q    <= 1'b0;
      key_outranks_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_CODEC_SELECT: codec_sel_q    <= cfg_wdata_i;
        CFG_KEY_OUTRANKS: key_outranks_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  lpnfc_front u_front (
    .in_valid_i   (in_valid_i),
    .frame_byte_i (frame_byte_i),
    .last_byte_i  (last_byte_i),
    .codec_sel_i  (codec_sel_q),
    .q_ready_i    (q_ready),
    .in_ready_o   (in_ready_o),
    .push_o       (push),
    .entry_o      (push_entry)
  );

  lpnfc_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .ready_o      (q_ready),
    .pop_i        (pop),
    .valid_o      (q_valid),
    .head_o       (head)
  );

  lpnfc_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .key_outranks_i (key_outranks_q),
    .q_valid_i      (q_valid),
    .q_head_i       (head),
    .pop_o          (pop),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .frame_kind_o   (frame_kind_o)
  );

endmodule
`default_nettype wire
